/* rtl/cbd_pkg.sv */
// Shared types, address map constants and decode function for the CPU bus decoder.
`default_nettype none
package cbd_pkg;

  localparam int RAM_DEPTH_DEF = 2048;
  localparam int RAM_DEPTH_MIN = 256;
  localparam int RAM_DEPTH_MAX = 8192;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [3:0] TGT_NONE  = 4'd0;
  localparam logic [3:0] TGT_RAM   = 4'd1;
  localparam logic [3:0] TGT_PIC   = 4'd2;
  localparam logic [3:0] TGT_SOUND = 4'd3;
  localparam logic [3:0] TGT_CTRL  = 4'd4;
  localparam logic [3:0] TGT_WRAM  = 4'd5;
  localparam logic [3:0] TGT_PROG  = 4'd6;
  localparam logic [3:0] TGT_DMA   = 4'd7;
  localparam logic [3:0] TGT_OAM   = 4'd8;

  localparam logic [15:0] ADDR_PIC      = 16'h2000;
  localparam logic [15:0] ADDR_IO       = 16'h4000;
  localparam logic [15:0] ADDR_DMA      = 16'h4014;
  localparam logic [15:0] ADDR_SND_STAT = 16'h4015;
  localparam logic [15:0] ADDR_CTRL1    = 16'h4016;
  localparam logic [15:0] ADDR_IO_END   = 16'h4018;
  localparam logic [15:0] ADDR_WRAM     = 16'h6000;
  localparam logic [15:0] ADDR_PROG     = 16'h8000;

  localparam logic [15:0] MASK_PIC  = 16'h0007;
  localparam logic [15:0] MASK_SND  = 16'h001F;
  localparam logic [15:0] MASK_WRAM = 16'h1FFF;
  localparam logic [15:0] MASK_PROG = 16'h7FFF;

  localparam int          RAM_SPAN_W = 13;
  localparam logic [2:0]  PH_READ    = 3'd0;
  localparam logic [2:0]  PH_WRITE   = 3'd3;
  localparam logic [2:0]  PH_LAST    = 3'd5;
  localparam logic [7:0]  IDX_LAST   = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  external_data;
  } req_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] local_address;
    logic [7:0]  data_out;
    logic        cpu_enable;
    logic        sound_enable;
    logic        dma_busy;
    logic [15:0] dma_source;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] local_address;
  } dec_t;

  function automatic dec_t decode(input logic [15:0] a, input logic wr);
    dec_t d;
    d.target        = TGT_NONE;
    d.local_address = '0;
    if (a < ADDR_PIC) begin
      d.target = TGT_RAM;
    end else if (a < ADDR_IO) begin
      d.target        = TGT_PIC;
      d.local_address = a & MASK_PIC;
    end else if (a < ADDR_IO_END) begin
      if (wr) begin
        if (a == ADDR_DMA) begin
          d.target = TGT_DMA;
        end else if (a == ADDR_CTRL1) begin
          d.target        = TGT_CTRL;
          d.local_address = a;
        end else begin
          d.target        = TGT_SOUND;
          d.local_address = a & MASK_SND;
        end
      end else begin
        if (a == ADDR_SND_STAT) begin
          d.target        = TGT_SOUND;
          d.local_address = a & MASK_SND;
        end else if (a > ADDR_SND_STAT) begin
          d.target        = TGT_CTRL;
          d.local_address = a;
        end
      end
    end else if (a < ADDR_WRAM) begin
      d.target = TGT_NONE;
    end else if (a < ADDR_PROG) begin
      d.target        = TGT_WRAM;
      d.local_address = a & MASK_WRAM;
    end else begin
      d.target        = TGT_PROG;
      d.local_address = a & MASK_PROG;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/cpu_bus_decoder_with_sprite_dma.sv */
// Top level: CPU bus decode, internal RAM, tick pacing and sprite DMA sequencing.
// Path: an accepted word is registered in s1 (RAM read), then in the output reg rsp.
// Throughput: one word per cycle unless rsp stalls; at most one RAM access per word.
// Reset: control state clears at once, then a sweep zeroes the RAM one entry a cycle,
// all RAM_DEPTH entries, with req_ready low throughout.
`default_nettype none
module cpu_bus_decoder_with_sprite_dma #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cbd_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output cbd_pkg::rsp_t      rsp
);

  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam int RAM_DEPTH_SPAN = 1 << cbd_pkg::RAM_SPAN_W;
  localparam int QB     = $clog2((RAM_DEPTH_SPAN + RAM_DEPTH - 1) / RAM_DEPTH);

  typedef struct packed {
    cbd_pkg::rsp_t payload;
    logic          use_ram;
    logic          latch_ram;
  } stage_t;

  // control state
  logic              clearing;
  logic [RAM_AW-1:0] clear_cnt;
  logic [2:0]        tick_phase;
  logic [7:0]        dma_page_reg;
  logic [7:0]        dma_index;
  logic [7:0]        dma_latch;
  logic              dma_align_wait;
  logic              dma_active;
  logic              s1_valid;
  stage_t            s1;

  // stage A decode
  logic              acc;
  logic              s1_adv;
  logic              is_rd, is_wr, is_tick;
  logic              slot;
  logic              dma_rd, dma_wr;
  logic [15:0]       bus_addr;
  cbd_pkg::dec_t     dec;
  logic [14:0]       rem;
  logic [RAM_AW-1:0] ram_idx;
  logic              hit_ram;
  logic [2:0]        tick_phase_next;
  logic [7:0]        dma_page_next;
  logic [7:0]        dma_index_next;
  logic              dma_align_next;
  logic              dma_active_next;
  stage_t            s1_next;
  cbd_pkg::rsp_t     rsp_next;

  // RAM port
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !clearing && (!s1_valid || s1_adv);
  assign acc       = req_valid && req_ready;

  assign is_rd   = req.command == cbd_pkg::CMD_READ;
  assign is_wr   = req.command == cbd_pkg::CMD_WRITE;
  assign is_tick = req.command == cbd_pkg::CMD_TICK;
  assign slot    = (tick_phase == cbd_pkg::PH_READ) || (tick_phase == cbd_pkg::PH_WRITE);
  assign dma_rd  = is_tick && slot && dma_active && !dma_align_wait
                   && (tick_phase == cbd_pkg::PH_READ);
  assign dma_wr  = is_tick && slot && dma_active && !dma_align_wait
                   && (tick_phase == cbd_pkg::PH_WRITE);

  assign bus_addr = dma_rd ? {dma_page_reg, dma_index} : req.address;
  assign dec      = cbd_pkg::decode(bus_addr, is_wr);
  assign hit_ram  = dec.target == cbd_pkg::TGT_RAM;

  // mirror fold: restoring subtract of shifted depth
  always_comb begin
    rem = {2'b00, bus_addr[cbd_pkg::RAM_SPAN_W-1:0]};
    for (int i = QB - 1; i >= 0; i--) begin
      if (rem >= 15'(RAM_DEPTH << i)) begin
        rem = rem - 15'(RAM_DEPTH << i);
      end
    end
  end
  assign ram_idx = rem[RAM_AW-1:0];

  always_comb begin
    tick_phase_next = tick_phase;
    dma_page_next   = dma_page_reg;
    dma_index_next  = dma_index;
    dma_align_next  = dma_align_wait;
    dma_active_next = dma_active;
    s1_next         = '0;
    case (req.command)
      cbd_pkg::CMD_READ: begin
        s1_next.payload.target        = dec.target;
        s1_next.payload.local_address = hit_ram ? 16'(ram_idx) : dec.local_address;
        s1_next.payload.data_out      = (dec.target == cbd_pkg::TGT_NONE) ? 8'd0
                                        : req.external_data;
        s1_next.use_ram               = hit_ram;
      end
      cbd_pkg::CMD_WRITE: begin
        s1_next.payload.target        = dec.target;
        s1_next.payload.local_address = hit_ram ? 16'(ram_idx) : dec.local_address;
        s1_next.payload.data_out      = (dec.target == cbd_pkg::TGT_NONE) ? 8'd0
                                        : req.write_data;
        if (dec.target == cbd_pkg::TGT_DMA) begin
          dma_page_next   = req.write_data;
          dma_index_next  = '0;
          dma_active_next = 1'b1;
        end
      end
      cbd_pkg::CMD_TICK: begin
        tick_phase_next = (tick_phase == cbd_pkg::PH_LAST) ? 3'd0 : tick_phase + 3'd1;
        if (slot) begin
          s1_next.payload.sound_enable = 1'b1;
          if (!dma_active) begin
            s1_next.payload.cpu_enable = 1'b1;
          end else if (dma_align_wait) begin
            if (tick_phase == cbd_pkg::PH_WRITE) begin
              dma_align_next = 1'b0;
            end
          end else if (dma_rd) begin
            s1_next.payload.target        = dec.target;
            s1_next.payload.local_address = hit_ram ? 16'(ram_idx) : dec.local_address;
            s1_next.payload.data_out      = (dec.target == cbd_pkg::TGT_NONE) ? 8'd0
                                            : req.external_data;
            s1_next.use_ram               = hit_ram;
            s1_next.latch_ram             = hit_ram;
          end else begin
            s1_next.payload.target        = cbd_pkg::TGT_OAM;
            s1_next.payload.local_address = 16'(dma_index);
            s1_next.payload.data_out      = dma_latch;
            dma_index_next                = dma_index + 8'd1;
            if (dma_index == cbd_pkg::IDX_LAST) begin
              dma_active_next = 1'b0;
              dma_align_next  = 1'b1;
            end
          end
        end
      end
      default: begin
        s1_next = '0;
      end
    endcase
    s1_next.payload.dma_busy   = dma_active_next;
    s1_next.payload.dma_source = {dma_page_next, dma_index_next};
  end

  assign ram_we    = clearing || (acc && is_wr && hit_ram);
  assign ram_re    = acc && !is_wr && hit_ram && (is_rd || dma_rd);
  assign ram_addr  = clearing ? clear_cnt : ram_idx;
  assign ram_wdata = clearing ? 8'd0 : req.write_data;

  cbd_ram #(
    .RAM_DEPTH(RAM_DEPTH),
    .RAM_AW   (RAM_AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing       <= 1'b1;
      clear_cnt      <= '0;
      tick_phase     <= '0;
      dma_page_reg   <= '0;
      dma_index      <= '0;
      dma_latch      <= '0;
      dma_align_wait <= 1'b1;
      dma_active     <= 1'b0;
      s1_valid       <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
        if (clear_cnt == RAM_AW'(RAM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      // latch RAM source byte once its read returns
      if (s1_valid && s1.latch_ram) begin
        dma_latch <= ram_rdata;
      end
      if (acc) begin
        tick_phase     <= tick_phase_next;
        dma_page_reg   <= dma_page_next;
        dma_index      <= dma_index_next;
        dma_align_wait <= dma_align_next;
        dma_active     <= dma_active_next;
        if (dma_rd && !hit_ram) begin
          dma_latch <= s1_next.payload.data_out;
        end
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp_next = s1.payload;
    if (s1.use_ram) begin
      rsp_next.data_out = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= s1_next;
    end
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

  a_cpu_off_in_dma: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.cpu_enable |-> !rsp.dma_busy)
    else $error("cpu enabled while sprite DMA runs");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    tick_phase <= cbd_pkg::PH_LAST)
    else $error("tick phase out of range");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_ready)
    else $error("word accepted during RAM clear");

  a_oam_needs_dma: assert property (@(posedge clk) disable iff (rst)
    acc && dma_wr |-> dma_active && !dma_align_wait)
    else $error("OAM write outside an active aligned DMA");

endmodule
`default_nettype wire

/* rtl/cbd_ram.sv */
// Single-port internal RAM with registered read data.
`default_nettype none
module cbd_ram #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF,
  parameter int RAM_AW    = $clog2(RAM_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [RAM_AW-1:0] addr,
  input  wire logic [7:0]        wdata,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire
